>>> rtl/gss_pkg.sv
// gss_pkg: shared widths, register codes, angle constants and the pipeline control type
// for the gimbal setpoint shaper; no dependencies
package gss_pkg;

    localparam int ANGLE_W = 31;
    localparam int TARGET_W = 32;
    localparam int LIMIT_W = 19;
    localparam int CFG_IDX_W = 2;
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int ANGLE_FRAC_BITS_MIN = 8;
    localparam int ANGLE_FRAC_BITS_MAX = 24;

    // s0 input register through s4 remainder register, then the result register
    localparam int PIPE_STAGES = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_YAW_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_CENTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIMIT = 2'd2;

    // 2*pi scaled by 2^32
    localparam logic [63:0] TWO_PI_2P32 = 64'd26986075409;

    typedef struct packed {
        logic [PIPE_STAGES:0]   load;
        logic [PIPE_STAGES-1:0] valid;
    } pipe_ctrl_t;

    function automatic logic [63:0] two_pi_q(input int frac);
        return (TWO_PI_2P32 + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

    function automatic logic [63:0] pi_q(input int frac);
        return (TWO_PI_2P32 + (64'd1 << (32 - frac))) >> (33 - frac);
    endfunction

    function automatic logic [63:0] quarter_pi_q(input int frac);
        return (TWO_PI_2P32 + (64'd1 << (34 - frac))) >> (35 - frac);
    endfunction

    // remainder before correction stays below twice the modulus
    function automatic int rem_width(input int frac);
        return $clog2(2 * two_pi_q(frac));
    endfunction

endpackage

>>> rtl/gss_cfg_regs.sv
// gss_cfg_regs: center and pitch limit configuration registers
// depends on gss_pkg
module gss_cfg_regs
    import gss_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [ANGLE_W-1:0]         cfg_data,
    output logic signed [ANGLE_W-1:0]  yaw_center,
    output logic signed [ANGLE_W-1:0]  pitch_center,
    output logic [LIMIT_W-1:0]         pitch_limit
);

    localparam logic [63:0] LIMIT_RESET64 = quarter_pi_q(ANGLE_FRAC_BITS);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_RESET64[LIMIT_W-1:0];

    logic signed [ANGLE_W-1:0] yaw_center_reg;
    logic signed [ANGLE_W-1:0] pitch_center_reg;
    logic [LIMIT_W-1:0]        pitch_limit_reg;
    logic                      wr;

    assign cfg_ready = 1'b1;
    assign wr = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_center_reg   <= '0;
            pitch_center_reg <= '0;
            pitch_limit_reg  <= LIMIT_RESET;
        end
        else if (wr)
        begin
            unique case (cfg_index)
                CFG_YAW_CENTER:   yaw_center_reg <= cfg_data;
                CFG_PITCH_CENTER: pitch_center_reg <= cfg_data;
                CFG_PITCH_LIMIT:  pitch_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign yaw_center   = yaw_center_reg;
    assign pitch_center = pitch_center_reg;
    assign pitch_limit  = pitch_limit_reg;

endmodule

>>> rtl/gss_pipe_ctrl.sv
// gss_pipe_ctrl: stage valid bits and load enables for the setpoint pipeline
// depends on gss_pkg
module gss_pipe_ctrl
    import gss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output pipe_ctrl_t ctrl
);

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [PIPE_STAGES:0]   adv;
    logic [PIPE_STAGES:0]   load;

    // a stage moves on when the next one is empty or moving too
    always_comb
    begin
        adv[PIPE_STAGES] = out_valid_reg && out_ready;
        for (int i = PIPE_STAGES - 1; i >= 0; i--)
        begin
            if (i == PIPE_STAGES - 1)
                adv[i] = valid_reg[i] && (!out_valid_reg || out_ready);
            else
                adv[i] = valid_reg[i] && (!valid_reg[i + 1] || adv[i + 1]);
        end
    end

    assign in_ready = !valid_reg[0] || adv[0];

    always_comb
    begin
        load[0] = in_valid && in_ready;
        for (int i = 1; i <= PIPE_STAGES; i++)
            load[i] = adv[i - 1];
        for (int i = 0; i < PIPE_STAGES; i++)
            valid_next[i] = load[i] || (valid_reg[i] && !adv[i]);
        out_valid_next = load[PIPE_STAGES] || (out_valid_reg && !adv[PIPE_STAGES]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ctrl.load  = load;
    assign ctrl.valid = valid_reg;

endmodule

>>> rtl/gss_yaw_path.sv
// gss_yaw_path: yaw error and its truncated remainder by two pi, via reciprocal multiply
// depends on gss_pkg and the load enables of gss_pipe_ctrl
module gss_yaw_path
    import gss_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    localparam int REM_W = rem_width(ANGLE_FRAC_BITS)
)
(
    input  logic                      clk,
    input  pipe_ctrl_t                ctrl,
    input  logic signed [ANGLE_W-1:0] yaw_center,
    input  logic signed [ANGLE_W-1:0] yaw_request,
    input  logic signed [ANGLE_W-1:0] measured_yaw,
    output logic [REM_W-1:0]          rem,
    output logic                      rem_neg,
    output logic signed [ANGLE_W-1:0] rem_meas
);

    localparam logic [63:0] MOD64 = two_pi_q(ANGLE_FRAC_BITS);
    localparam logic [63:0] RECIP64 = (64'd1 << 32) / MOD64;
    localparam logic [31:0] MOD32 = MOD64[31:0];
    localparam logic [31:0] RECIP32 = RECIP64[31:0];
    localparam logic [REM_W-1:0] MOD_R = MOD64[REM_W-1:0];

    // s0
    logic signed [ANGLE_W-1:0] yreq0_reg;
    logic signed [ANGLE_W-1:0] meas0_reg;
    // s1
    logic [31:0]               mag1_reg;
    logic                      neg1_reg;
    logic signed [ANGLE_W-1:0] meas1_reg;
    // s2
    logic [31:0]               quot2_reg;
    logic [31:0]               mag2_reg;
    logic                      neg2_reg;
    logic signed [ANGLE_W-1:0] meas2_reg;
    // s3
    logic [31:0]               qmod3_reg;
    logic [31:0]               mag3_reg;
    logic                      neg3_reg;
    logic signed [ANGLE_W-1:0] meas3_reg;
    // s4
    logic [REM_W-1:0]          rem4_reg;
    logic                      neg4_reg;
    logic signed [ANGLE_W-1:0] meas4_reg;

    logic signed [32:0] raw;
    logic [32:0]        raw_abs;
    logic [63:0]        recip_prod;
    logic [63:0]        qmod_prod;
    logic [31:0]        rem_pre;
    logic [REM_W-1:0]   rem_next;

    always_comb
    begin
        raw = 33'(yreq0_reg) + 33'(yaw_center) - 33'(meas0_reg);
        raw_abs = raw[32] ? 33'(-raw) : 33'(raw);
        recip_prod = {32'd0, mag1_reg} * {32'd0, RECIP32};
        qmod_prod = {32'd0, quot2_reg} * {32'd0, MOD32};
        rem_pre = mag3_reg - qmod3_reg;
        if (rem_pre[REM_W-1:0] >= MOD_R)
            rem_next = rem_pre[REM_W-1:0] - MOD_R;
        else
            rem_next = rem_pre[REM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            yreq0_reg <= yaw_request;
            meas0_reg <= measured_yaw;
        end
        if (ctrl.load[1])
        begin
            mag1_reg  <= raw_abs[31:0];
            neg1_reg  <= raw[32];
            meas1_reg <= meas0_reg;
        end
        if (ctrl.load[2])
        begin
            quot2_reg <= recip_prod[63:32];
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            meas2_reg <= meas1_reg;
        end
        if (ctrl.load[3])
        begin
            qmod3_reg <= qmod_prod[31:0];
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            meas3_reg <= meas2_reg;
        end
        if (ctrl.load[4])
        begin
            rem4_reg  <= rem_next;
            neg4_reg  <= neg3_reg;
            meas4_reg <= meas3_reg;
        end
    end

    assign rem      = rem4_reg;
    assign rem_neg  = neg4_reg;
    assign rem_meas = meas4_reg;

endmodule

>>> rtl/gss_pitch_path.sv
// gss_pitch_path: pitch offset by center and clamped to the travel limit
// depends on gss_pkg and the load enables of gss_pipe_ctrl
module gss_pitch_path
    import gss_pkg::*;
(
    input  logic                       clk,
    input  pipe_ctrl_t                 ctrl,
    input  logic signed [ANGLE_W-1:0]  pitch_center,
    input  logic [LIMIT_W-1:0]         pitch_limit,
    input  logic signed [ANGLE_W-1:0]  pitch_request,
    output logic signed [TARGET_W-1:0] pitch_out
);

    logic signed [ANGLE_W-1:0]  preq0_reg;
    logic signed [TARGET_W-1:0] psum1_reg;
    logic signed [TARGET_W-1:0] pitch2_reg;
    logic signed [TARGET_W-1:0] pitch3_reg;
    logic signed [TARGET_W-1:0] pitch4_reg;

    logic signed [TARGET_W-1:0] psum;
    logic signed [TARGET_W-1:0] hi;
    logic signed [TARGET_W-1:0] lo;
    logic signed [TARGET_W-1:0] clamped;

    always_comb
    begin
        psum = TARGET_W'(preq0_reg) + TARGET_W'(pitch_center);
        hi = TARGET_W'(pitch_center) + $signed({{(TARGET_W-LIMIT_W){1'b0}}, pitch_limit});
        lo = TARGET_W'(pitch_center) - $signed({{(TARGET_W-LIMIT_W){1'b0}}, pitch_limit});
        priority if (psum1_reg < lo)
            clamped = lo;
        else if (psum1_reg > hi)
            clamped = hi;
        else
            clamped = psum1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
            preq0_reg <= pitch_request;
        if (ctrl.load[1])
            psum1_reg <= psum;
        if (ctrl.load[2])
            pitch2_reg <= clamped;
        if (ctrl.load[3])
            pitch3_reg <= pitch2_reg;
        if (ctrl.load[4])
            pitch4_reg <= pitch3_reg;
    end

    assign pitch_out = pitch4_reg;

endmodule

>>> rtl/gimbal_setpoint_shaper_unit.sv
// Gimbal setpoint shaper: turns relative yaw/pitch requests into physical setpoints.
// One item is accepted per cycle unless the output stalls; it passes through the input
// register s0, stages s1 to s4, then the result register; depth is set by the two
// registered multiplies of the yaw remainder by two pi and its correction step. A stalled
// result holds the full stages directly behind it; stages behind a gap still advance.
// A rejected yaw request returns the held yaw target. No clearing pass after reset.
// Depends on gss_pkg, gss_cfg_regs, gss_pipe_ctrl, gss_yaw_path and gss_pitch_path.
module gimbal_setpoint_shaper_unit
    import gss_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [ANGLE_W-1:0]         cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [ANGLE_W-1:0]  yaw_request,
    input  logic signed [ANGLE_W-1:0]  pitch_request,
    input  logic signed [ANGLE_W-1:0]  measured_yaw,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [TARGET_W-1:0] yaw_target,
    output logic signed [TARGET_W-1:0] pitch_target,
    output logic                       yaw_accepted
);

    localparam int REM_W = rem_width(ANGLE_FRAC_BITS);
    localparam logic [63:0] PI64 = pi_q(ANGLE_FRAC_BITS);
    localparam logic [TARGET_W-1:0] PI_T = PI64[TARGET_W-1:0];
    localparam logic [63:0] MOD64 = two_pi_q(ANGLE_FRAC_BITS);
    localparam logic [REM_W-1:0] MOD_R = MOD64[REM_W-1:0];

    pipe_ctrl_t                ctrl;
    logic signed [ANGLE_W-1:0] yaw_center;
    logic signed [ANGLE_W-1:0] pitch_center;
    logic [LIMIT_W-1:0]        pitch_limit;
    logic [REM_W-1:0]          rem;
    logic                      rem_neg;
    logic signed [ANGLE_W-1:0] rem_meas;
    logic signed [TARGET_W-1:0] pitch_out;

    logic signed [TARGET_W-1:0] yaw_target_reg;
    logic signed [TARGET_W-1:0] yaw_target_next;
    logic signed [TARGET_W-1:0] pitch_target_reg;
    logic                       yaw_accepted_reg;
    logic signed [TARGET_W-1:0] held_yaw_target_reg;
    logic signed [TARGET_W-1:0] held_yaw_target_next;

    logic [TARGET_W-1:0]        rem_ext;
    logic signed [TARGET_W-1:0] delta;
    logic signed [TARGET_W-1:0] new_yaw;
    logic                       yaw_ok;

    gss_cfg_regs #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .yaw_center   (yaw_center),
        .pitch_center (pitch_center),
        .pitch_limit  (pitch_limit)
    );

    gss_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    gss_yaw_path #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_yaw (
        .clk          (clk),
        .ctrl         (ctrl),
        .yaw_center   (yaw_center),
        .yaw_request  (yaw_request),
        .measured_yaw (measured_yaw),
        .rem          (rem),
        .rem_neg      (rem_neg),
        .rem_meas     (rem_meas)
    );

    gss_pitch_path u_pitch (
        .clk           (clk),
        .ctrl          (ctrl),
        .pitch_center  (pitch_center),
        .pitch_limit   (pitch_limit),
        .pitch_request (pitch_request),
        .pitch_out     (pitch_out)
    );

    // signed remainder follows the sign of the yaw error
    always_comb
    begin
        rem_ext = {{(TARGET_W-REM_W){1'b0}}, rem};
        yaw_ok = rem_ext <= PI_T;
        delta = rem_neg ? -$signed(rem_ext) : $signed(rem_ext);
        new_yaw = TARGET_W'(rem_meas) + delta;
        yaw_target_next = yaw_ok ? new_yaw : held_yaw_target_reg;
        held_yaw_target_next = held_yaw_target_reg;
        if (ctrl.load[PIPE_STAGES] && yaw_ok)
            held_yaw_target_next = new_yaw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_yaw_target_reg <= '0;
        else
            held_yaw_target_reg <= held_yaw_target_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[PIPE_STAGES])
        begin
            yaw_target_reg   <= yaw_target_next;
            pitch_target_reg <= pitch_out;
            yaw_accepted_reg <= yaw_ok;
        end
    end

    assign yaw_target   = yaw_target_reg;
    assign pitch_target = pitch_target_reg;
    assign yaw_accepted = yaw_accepted_reg;

    // a result beat always carries the target now held
    a_target_is_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> yaw_target_reg == held_yaw_target_reg)
        else $error("yaw target differs from held target");

    // held target only moves when a result is loaded
    a_held_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.load[PIPE_STAGES] |=> $stable(held_yaw_target_reg))
        else $error("held yaw target changed without a result");

    // a rejected request leaves the held target alone
    a_reject_keeps_held: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load[PIPE_STAGES] && !yaw_ok |=> $stable(held_yaw_target_reg))
        else $error("rejected yaw request changed held target");

    // corrected remainder is below the modulus
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.valid[PIPE_STAGES-1] |-> rem < MOD_R)
        else $error("yaw remainder not reduced");

endmodule

>>> tb/sv/gimbal_setpoint_shaper_unit_tb.sv
`timescale 1ns / 1ps
// gimbal_setpoint_shaper_unit_tb: directed table and constrained-random setpoint requests,
// each beat checked against its table row or a behavioral model of yaw wrap and pitch clamp
// depends on gss_pkg and gimbal_setpoint_shaper_unit
module gimbal_setpoint_shaper_unit_tb;
    import gss_pkg::*;

    localparam longint TWO_PI_FIX = 411775;
    localparam longint PI_FIX = 205887;
    localparam logic [LIMIT_W-1:0] PITCH_LIMIT_RESET = 19'd51472;
    localparam logic signed [ANGLE_W-1:0] ANG_MAX = 31'sh3FFFFFFF;
    localparam logic signed [ANGLE_W-1:0] ANG_MIN = 31'sh40000000;
    localparam int DIRECTED_ROWS = 18;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 235;

    typedef struct packed {
        logic signed [TARGET_W-1:0] yaw_target;
        logic signed [TARGET_W-1:0] pitch_target;
        logic                       yaw_accepted;
    } setpoint_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] yaw_req;
        logic signed [ANGLE_W-1:0] pitch_req;
        logic signed [ANGLE_W-1:0] meas_yaw;
        logic                      fixed;
        setpoint_t                 want;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [ANGLE_W-1:0]         cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [ANGLE_W-1:0]  yaw_request;
    logic signed [ANGLE_W-1:0]  pitch_request;
    logic signed [ANGLE_W-1:0]  measured_yaw;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [TARGET_W-1:0] yaw_target;
    logic signed [TARGET_W-1:0] pitch_target;
    logic                       yaw_accepted;

    logic signed [ANGLE_W-1:0]  yaw_center_q;
    logic signed [ANGLE_W-1:0]  pitch_center_q;
    logic [LIMIT_W-1:0]         pitch_limit_q;
    logic signed [TARGET_W-1:0] held_yaw_q;

    setpoint_t pending_setpoints[$];
    stim_row_t directed_rows[DIRECTED_ROWS];
    int        mismatch_count = 0;
    bit        no_gaps = 1'b0;

    gimbal_setpoint_shaper_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .yaw_request   (yaw_request),
        .pitch_request (pitch_request),
        .measured_yaw  (measured_yaw),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .yaw_target    (yaw_target),
        .pitch_target  (pitch_target),
        .yaw_accepted  (yaw_accepted)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic setpoint_t shape_setpoint(input logic signed [ANGLE_W-1:0] yr,
                                                 input logic signed [ANGLE_W-1:0] pr,
                                                 input logic signed [ANGLE_W-1:0] my);
        longint    pitch;
        longint    hi;
        longint    lo;
        longint    raw;
        longint    d;
        setpoint_t r;
        pitch = longint'(pr) + longint'(pitch_center_q);
        hi = longint'(pitch_center_q) + longint'({1'b0, pitch_limit_q});
        lo = longint'(pitch_center_q) - longint'({1'b0, pitch_limit_q});
        if (pitch > hi)
            pitch = hi;
        if (pitch < lo)
            pitch = lo;
        raw = longint'(yr) + longint'(yaw_center_q) - longint'(my);
        d = raw % TWO_PI_FIX;
        r.yaw_accepted = (d <= PI_FIX) && (d >= -PI_FIX);
        if (r.yaw_accepted)
            held_yaw_q = 32'(longint'(my) + d);
        r.yaw_target = held_yaw_q;
        r.pitch_target = pitch[TARGET_W-1:0];
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_YAW_CENTER:   yaw_center_q = data;
            CFG_PITCH_CENTER: pitch_center_q = data;
            CFG_PITCH_LIMIT:  pitch_limit_q = data[LIMIT_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic load_setting(input logic signed [ANGLE_W-1:0] yc,
                                input logic signed [ANGLE_W-1:0] pc,
                                input logic [LIMIT_W-1:0] pl);
        write_reg(CFG_YAW_CENTER, yc);
        write_reg(CFG_PITCH_CENTER, pc);
        write_reg(CFG_PITCH_LIMIT, ANGLE_W'(pl));
        cfg_valid <= 1'b0;
    endtask

    task automatic pause_sender();
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_setpoint(input logic signed [ANGLE_W-1:0] yr,
                                 input logic signed [ANGLE_W-1:0] pr,
                                 input logic signed [ANGLE_W-1:0] my,
                                 input logic fixed, input setpoint_t want);
        setpoint_t predicted;
        in_valid <= 1'b1;
        yaw_request <= yr;
        pitch_request <= pr;
        measured_yaw <= my;
        do @(posedge clk); while (in_ready !== 1'b1);
        predicted = shape_setpoint(yr, pr, my);
        pending_setpoints.push_back(fixed ? want : predicted);
    endtask

    task automatic wait_drained();
        while (pending_setpoints.size() != 0)
            @(posedge clk);
    endtask

    // mostly yaw near the half-turn boundary or within a turn, pitch to just past its limits
    task automatic random_request(output logic signed [ANGLE_W-1:0] yr,
                                  output logic signed [ANGLE_W-1:0] pr,
                                  output logic signed [ANGLE_W-1:0] my);
        longint base;
        longint cand;
        int     lim;
        my = ANGLE_W'($urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            yr = ANGLE_W'($urandom);
            pr = ANGLE_W'($urandom);
        end
        else
        begin
            lim = int'({1'b0, pitch_limit_q});
            pr = ANGLE_W'(longint'($urandom_range(0, 2 * lim + 40)) - lim - 20);
            base = longint'(my) - longint'(yaw_center_q)
                   + (longint'($urandom_range(0, 6)) - 3) * TWO_PI_FIX;
            if ($urandom_range(0, 1) == 1)
                cand = base + ($urandom_range(0, 1) == 1 ? PI_FIX : -PI_FIX)
                       + longint'($urandom_range(0, 4)) - 2;
            else
                cand = base + longint'($urandom_range(0, 32'(2 * TWO_PI_FIX))) - TWO_PI_FIX;
            if (cand >= longint'(ANG_MIN) && cand <= longint'(ANG_MAX))
                yr = cand[ANGLE_W-1:0];
            else
                yr = ANGLE_W'($urandom);
        end
    endtask

    task automatic check_field(input string field, input logic signed [TARGET_W-1:0] want,
                               input logic signed [TARGET_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    initial
    begin : result_side
        int        stall;
        setpoint_t want;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            if (pending_setpoints.size() == 0)
            begin
                $display("%0t unexpected beat: expected none, actual yaw %0d pitch %0d acc %0d",
                         $time, yaw_target, pitch_target, yaw_accepted);
                mismatch_count++;
            end
            else
            begin
                want = pending_setpoints.pop_front();
                check_field("yaw_target", want.yaw_target, yaw_target);
                check_field("pitch_target", want.pitch_target, pitch_target);
                check_field("yaw_accepted", TARGET_W'(want.yaw_accepted),
                            TARGET_W'(yaw_accepted));
            end
        end
    end

    initial
    begin : request_side
        stim_row_t                 row;
        logic signed [ANGLE_W-1:0] yr;
        logic signed [ANGLE_W-1:0] pr;
        logic signed [ANGLE_W-1:0] my;
        logic [LIMIT_W-1:0]        pl;

        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_YAW_CENTER;
        cfg_data <= '0;
        in_valid <= 1'b0;
        yaw_request <= '0;
        pitch_request <= '0;
        measured_yaw <= '0;
        yaw_center_q = '0;
        pitch_center_q = '0;
        pitch_limit_q = PITCH_LIMIT_RESET;
        held_yaw_q = '0;

        // reset register values: centers at zero, pitch limit an eighth turn
        directed_rows = '{
            '{31'sd300000, ANG_MAX, 31'sd0, 1'b1, '{32'sd0, 32'sd51472, 1'b0}},
            '{31'sd205887, ANG_MIN, 31'sd0, 1'b1, '{32'sd205887, -32'sd51472, 1'b1}},
            '{-31'sd205887, 31'sd0, 31'sd0, 1'b1, '{-32'sd205887, 32'sd0, 1'b1}},
            '{-31'sd205888, 31'sd51472, 31'sd0, 1'b1, '{-32'sd205887, 32'sd51472, 1'b0}},
            '{31'sd205888, -31'sd51473, 31'sd0, 1'b1, '{-32'sd205887, -32'sd51472, 1'b0}},
            '{31'sd0, 31'sd51471, 31'sd0, 1'b1, '{32'sd0, 32'sd51471, 1'b1}},
            '{31'sd411775, 31'sd0, 31'sd0, 1'b1, '{32'sd0, 32'sd0, 1'b1}},
            '{31'sd411875, -31'sd51472, 31'sd0, 1'b1, '{32'sd100, -32'sd51472, 1'b1}},
            '{ANG_MAX, ANG_MAX, ANG_MIN, 1'b0, '0},
            '{ANG_MIN, ANG_MIN, ANG_MAX, 1'b0, '0},
            '{ANG_MAX, ANG_MAX, ANG_MAX, 1'b1, '{32'sd1073741823, 32'sd51472, 1'b1}},
            '{ANG_MIN, ANG_MIN, ANG_MIN, 1'b1, '{-32'sd1073741824, -32'sd51472, 1'b1}},
            '{31'sd0, 31'sd12345, ANG_MAX, 1'b0, '0},
            '{31'sd0, -31'sd12345, ANG_MIN, 1'b0, '0},
            '{-31'sd1029437, 31'sd0, 31'sd0, 1'b1, '{-32'sd205887, 32'sd0, 1'b1}},
            '{31'sd1029438, 31'sd0, 31'sd0, 1'b1, '{-32'sd205887, 32'sd0, 1'b0}},
            '{31'sd5000, -31'sd1, 31'sd1000000, 1'b0, '0},
            '{31'h2AAAAAAA, 31'h55555555, 31'h55555555, 1'b0, '0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            pause_sender();
            send_setpoint(row.yaw_req, row.pitch_req, row.meas_yaw, row.fixed, row.want);
        end
        in_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       load_setting(ANG_MAX, ANG_MIN, 19'd411775);
                1:       load_setting(ANG_MIN, ANG_MAX, 19'd0);
                3:       load_setting(ANGLE_W'($urandom), ANGLE_W'($urandom),
                                      LIMIT_W'($urandom_range(0, 64)));
                default:
                begin
                    pl = LIMIT_W'($urandom_range(0, 411775));
                    load_setting(ANGLE_W'($urandom), ANGLE_W'($urandom), pl);
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    no_gaps = ~no_gaps;
                random_request(yr, pr, my);
                pause_sender();
                send_setpoint(yr, pr, my, 1'b0, '0);
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (12) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
